>>> design/blr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int DIM_BITS     = 13;   // screen width / height registers
    localparam int ADDR_BITS    = 24;   // linear pixel address
    localparam int CHAN_BITS    = 8;    // one colour component
    localparam int CFG_IDX_BITS = 1;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(4096);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    // input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] alpha;
    } t_rgba;

    // per-pixel attributes carried from the step stage to the address stage
    typedef struct packed {
        logic  last;
        t_rgba colour;
    } t_pix_tag;

endpackage

>>> design/blr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_ifs
// Valid/ready channels of the line rasterizer: line command in, pixel out.
// ----------------------------------------------------------------------------
interface blr_in_if #(
    parameter int COORD_BITS = 12
);
    import blr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [CHAN_BITS-1:0]  red_in;
    logic [CHAN_BITS-1:0]  green_in;
    logic [CHAN_BITS-1:0]  blue_in;
    logic [CHAN_BITS-1:0]  alpha_in;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y,
               red_in, green_in, blue_in, alpha_in,
        input  ready
    );

    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y,
               red_in, green_in, blue_in, alpha_in,
        output ready
    );
endinterface

interface blr_out_if #(
    parameter int COORD_BITS = 12
);
    import blr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  write_address;
    logic                  write_enable;
    logic                  last_pixel;
    logic [CHAN_BITS-1:0]  red_out;
    logic [CHAN_BITS-1:0]  green_out;
    logic [CHAN_BITS-1:0]  blue_out;
    logic [CHAN_BITS-1:0]  alpha_out;

    modport source (
        output valid, pixel_x, pixel_y, write_address, write_enable, last_pixel,
               red_out, green_out, blue_out, alpha_out,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, write_address, write_enable, last_pixel,
               red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

>>> design/blr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_step
// Line state and Bresenham step: sets up a line on start, emits the cursor
// pixel and advances one step per step command.
// ----------------------------------------------------------------------------
module blr_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    blr_in_if.sink                i_line,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output blr_pkg::t_pix_tag     o_tag,
    output logic                  o_line_active
);
    import blr_pkg::*;

    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = COORD_BITS + 3;

    logic                  r_active;
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic                  r_neg_x, r_neg_y;
    logic [ERR_W-1:0]      r_err;
    t_rgba                 r_colour;

    logic                  r_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    t_pix_tag              r_tag;

    logic                  w_accept, w_start, w_produce, w_last;
    logic [COORD_BITS-1:0] n_dx, n_dy;
    logic signed [E2_W-1:0] w_e2, w_dx_s, w_ndy, w_err_sum;
    logic                  w_move_x, w_move_y;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y;

    assign i_line.ready = !r_valid || i_ready;
    assign w_accept     = i_line.valid && i_line.ready;
    assign w_start      = w_accept && (i_line.mode == MODE_START);
    assign w_produce    = w_accept && (i_line.mode == MODE_STEP) && r_active;
    assign w_last       = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    // setup: absolute deltas
    assign n_dx = (i_line.end_x >= i_line.start_x) ? i_line.end_x - i_line.start_x
                                                   : i_line.start_x - i_line.end_x;
    assign n_dy = (i_line.end_y >= i_line.start_y) ? i_line.end_y - i_line.start_y
                                                   : i_line.start_y - i_line.end_y;

    // step decision on 2*err against -dy and dx
    always_comb begin
        w_e2      = {r_err, 1'b0};
        w_dx_s    = signed'({3'b000, r_dx});
        w_ndy     = -signed'({3'b000, r_dy});
        w_move_x  = w_e2 > w_ndy;
        w_move_y  = w_e2 < w_dx_s;
        w_err_sum = signed'({r_err[ERR_W-1], r_err});
        if (w_move_x) begin
            w_err_sum = w_err_sum + w_ndy;
        end
        if (w_move_y) begin
            w_err_sum = w_err_sum + w_dx_s;
        end
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (w_move_x) begin
            n_cur_x = r_neg_x ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (w_move_y) begin
            n_cur_y = r_neg_y ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= w_produce;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_start) begin
                r_active <= 1'b1;
            end else if (w_produce && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cur_x         <= i_line.start_x;
            r_cur_y         <= i_line.start_y;
            r_tgt_x         <= i_line.end_x;
            r_tgt_y         <= i_line.end_y;
            r_dx            <= n_dx;
            r_dy            <= n_dy;
            r_neg_x         <= !(i_line.start_x < i_line.end_x);
            r_neg_y         <= !(i_line.start_y < i_line.end_y);
            r_err           <= {2'b00, n_dx} - {2'b00, n_dy};
            r_colour.red    <= i_line.red_in;
            r_colour.green  <= i_line.green_in;
            r_colour.blue   <= i_line.blue_in;
            r_colour.alpha  <= i_line.alpha_in;
        end else if (w_produce && !w_last) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= w_err_sum[ERR_W-1:0];
        end
        if (w_produce) begin
            r_px         <= r_cur_x;
            r_py         <= r_cur_y;
            r_tag.last   <= w_last;
            r_tag.colour <= r_colour;
        end
    end

    assign o_valid       = r_valid;
    assign o_x           = r_px;
    assign o_y           = r_py;
    assign o_tag         = r_tag;
    assign o_line_active = r_active;

endmodule

>>> design/blr_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_addr
// Address and clip stage: forms y*width+x, the on-screen flag, and holds the
// finished pixel in the output register.
// ----------------------------------------------------------------------------
module blr_addr #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [COORD_BITS-1:0]         i_x,
    input  logic [COORD_BITS-1:0]         i_y,
    input  blr_pkg::t_pix_tag             i_tag,
    input  logic [blr_pkg::DIM_BITS-1:0]  i_width,
    input  logic [blr_pkg::DIM_BITS-1:0]  i_height,
    blr_out_if.source                     o_pixel
);
    import blr_pkg::*;

    localparam int PROD_W = (COORD_BITS + DIM_BITS > ADDR_BITS) ?
                            COORD_BITS + DIM_BITS : ADDR_BITS;
    localparam int CMP_W  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    logic                  r_valid;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [ADDR_BITS-1:0]  r_addr;
    logic                  r_we;
    t_pix_tag              r_tag;

    logic [PROD_W-1:0]     w_prod;
    logic [ADDR_BITS-1:0]  w_addr;
    logic                  w_inside, w_load;

    assign o_ready = !r_valid || o_pixel.ready;
    assign w_load  = i_valid && o_ready;

    assign w_prod   = PROD_W'(i_y) * PROD_W'(i_width);
    assign w_addr   = w_prod[ADDR_BITS-1:0] + ADDR_BITS'(i_x);
    assign w_inside = (CMP_W'(i_x) < CMP_W'(i_width)) && (CMP_W'(i_y) < CMP_W'(i_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_addr <= w_addr;
            r_we   <= w_inside;
            r_tag  <= i_tag;
        end
    end

    assign o_pixel.valid         = r_valid;
    assign o_pixel.pixel_x       = r_x;
    assign o_pixel.pixel_y       = r_y;
    assign o_pixel.write_address = r_addr;
    assign o_pixel.write_enable  = r_we;
    assign o_pixel.last_pixel    = r_tag.last;
    assign o_pixel.red_out       = r_tag.colour.red;
    assign o_pixel.green_out     = r_tag.colour.green;
    assign o_pixel.blue_out      = r_tag.colour.blue;
    assign o_pixel.alpha_out     = r_tag.colour.alpha;

endmodule

>>> design/bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
// A step command's pixel passes through the step stage register and the address stage register to o_pixel.
// Throughput: one command per cycle while the pixel output does not stall; the step stage updates
//   the error term and cursor combinationally and the address stage holds one multiply-add.
// Start commands produce no pixel.
// Reset (synchronous, active low) clears the line, both pipeline stages and
//   sets screen width and height to 4096.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// All-octant integer line rasterizer emitting one clipped, addressed pixel
// per step command while a line is active.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    blr_in_if.sink                            i_line,
    blr_out_if.source                         o_pixel,
    input  logic                              i_cfg_wr_en,
    input  logic [blr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [blr_pkg::DIM_BITS-1:0]      i_cfg_wdata
);
    import blr_pkg::*;

    logic [DIM_BITS-1:0]   r_width, r_height;
    logic                  w_s1_valid, w_s1_ready, w_line_active;
    logic [COORD_BITS-1:0] w_s1_x, w_s1_y;
    t_pix_tag              w_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    blr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line        (i_line),
        .o_valid       (w_s1_valid),
        .i_ready       (w_s1_ready),
        .o_x           (w_s1_x),
        .o_y           (w_s1_y),
        .o_tag         (w_s1_tag),
        .o_line_active (w_line_active)
    );

    blr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s1_valid),
        .o_ready  (w_s1_ready),
        .i_x      (w_s1_x),
        .i_y      (w_s1_y),
        .i_tag    (w_s1_tag),
        .i_width  (r_width),
        .i_height (r_height),
        .o_pixel  (o_pixel)
    );

    // a start command never leaves a pixel in the step stage
    a_start_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_line.valid && i_line.ready && i_line.mode == MODE_START) |=> !w_s1_valid)
        else $error("pixel produced by start command");

    // a step with no active line produces nothing
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_line.valid && i_line.ready && i_line.mode == MODE_STEP && !w_line_active)
        |=> !w_s1_valid)
        else $error("pixel produced without an active line");

    // the last pixel of a line ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(w_s1_valid) && w_s1_tag.last) |-> !w_line_active)
        else $error("line still active after its last pixel");

    // write enable only for on-screen columns
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.write_enable) |->
        ({1'b0, o_pixel.pixel_x} < {1'b0, r_width} || COORD_BITS > DIM_BITS))
        else $error("write enable on an off-screen column");

endmodule
